// ===== sv/wadet_pkg.sv =====
// Package for the window amplitude event detector.
// Holds widths, register reset values, class and alert codes and the result record.
// No dependencies.
`default_nettype none

package wadet_pkg;

  localparam int unsigned WINDOW_DEF      = 256;
  localparam int unsigned SAMPLE_BITS_DEF = 12;
  localparam int unsigned CODE_W          = 12;
  localparam int unsigned THR_W           = 20;
  localparam int unsigned CNT_W           = 32;
  localparam int unsigned CFG_AW          = 4;
  localparam int unsigned CFG_DW          = 32;

  localparam logic [THR_W-1:0] QUAKE_THR_RST  = 20'd914900;
  localparam logic [THR_W-1:0] TREMOR_THR_RST = 20'd365960;
  localparam logic [THR_W-1:0] HIGH_THR_RST   = 20'd548940;

  localparam logic REQ_PUSH     = 1'b0;
  localparam logic REQ_CLASSIFY = 1'b1;

  typedef enum logic [1:0] {
    CLS_INSUFFICIENT,
    CLS_NOISE,
    CLS_TREMOR,
    CLS_QUAKE
  } event_class_t;

  typedef enum logic [1:0] {
    LVL_NONE,
    LVL_LOW,
    LVL_HIGH,
    LVL_CRITICAL
  } alert_level_t;

  typedef enum logic [1:0] {
    REG_QUAKE_THR,
    REG_TREMOR_THR,
    REG_HIGH_THR
  } reg_index_t;

  typedef struct packed {
    logic [THR_W-1:0] quake;
    logic [THR_W-1:0] tremor;
    logic [THR_W-1:0] high;
  } thresholds_t;

  typedef struct packed {
    event_class_t     event_class;
    alert_level_t     alert_level;
    logic [THR_W-1:0] window_sum;
    logic [CNT_W-1:0] total_count;
    logic [CNT_W-1:0] high_count;
    logic [CNT_W-1:0] critical_count;
  } result_t;

endpackage

`default_nettype wire

// ===== sv/wadet_cell.sv =====
// One stage of the magnitude delay line: holds one sample magnitude.
// Depends on nothing but its parameter.
`default_nettype none

module wadet_cell #(
  parameter int unsigned WIDTH = 12
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             shift_en,
  input  wire logic [WIDTH-1:0] din,
  output logic      [WIDTH-1:0] dout
);

  logic [WIDTH-1:0] mag_r;
  logic [WIDTH-1:0] mag_nxt;

  always_comb begin
    mag_nxt = shift_en ? din : mag_r;
  end

  // The line starts empty: an empty stage counts as zero in the sum.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mag_r <= '0;
    end else begin
      mag_r <= mag_nxt;
    end
  end

  assign dout = mag_r;

endmodule

`default_nettype wire

// ===== sv/wadet_classify.sv =====
// Threshold compare and event counters of the window amplitude event detector.
// Depends on wadet_pkg.
`default_nettype none

module wadet_classify
  import wadet_pkg::*;
#(
  parameter int unsigned SUM_W = 20
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             classify_go,
  input  wire logic             window_full,
  input  wire logic [SUM_W-1:0] sum,
  input  wire thresholds_t      thr,
  output result_t               result
);

  localparam int unsigned CMP_W = (SUM_W > THR_W) ? SUM_W : THR_W;

  logic [CNT_W-1:0] total_r, total_nxt;
  logic [CNT_W-1:0] high_r, high_nxt;
  logic [CNT_W-1:0] crit_r, crit_nxt;
  logic [CMP_W-1:0] sum_ext;
  logic [CMP_W-1:0] quake_ext;
  logic [CMP_W-1:0] tremor_ext;
  logic [CMP_W-1:0] high_ext;
  logic [CMP_W-1:0] sum_hi;
  event_class_t     cls;
  alert_level_t     lvl;

  assign sum_ext    = CMP_W'(sum);
  assign quake_ext  = CMP_W'(thr.quake);
  assign tremor_ext = CMP_W'(thr.tremor);
  assign high_ext   = CMP_W'(thr.high);
  assign sum_hi     = sum_ext >> THR_W;

  always_comb begin
    cls       = CLS_NOISE;
    lvl       = LVL_NONE;
    total_nxt = total_r;
    high_nxt  = high_r;
    crit_nxt  = crit_r;
    if (!window_full) begin
      cls = CLS_INSUFFICIENT;
    end else if (sum_ext > quake_ext) begin
      cls       = CLS_QUAKE;
      lvl       = LVL_CRITICAL;
      total_nxt = total_r + 1'b1;
      crit_nxt  = crit_r + 1'b1;
    end else if (sum_ext > tremor_ext) begin
      cls       = CLS_TREMOR;
      total_nxt = total_r + 1'b1;
      if (sum_ext >= high_ext) begin
        lvl      = LVL_HIGH;
        high_nxt = high_r + 1'b1;
      end else begin
        lvl = LVL_LOW;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r <= '0;
      high_r  <= '0;
      crit_r  <= '0;
    end else if (classify_go) begin
      total_r <= total_nxt;
      high_r  <= high_nxt;
      crit_r  <= crit_nxt;
    end
  end

  // Report the counts after this request; saturate the reported sum only.
  always_comb begin
    result.event_class    = cls;
    result.alert_level    = lvl;
    result.window_sum     = (sum_hi != '0) ? {THR_W{1'b1}} : sum_ext[THR_W-1:0];
    result.total_count    = total_nxt;
    result.high_count     = high_nxt;
    result.critical_count = crit_nxt;
  end

endmodule

`default_nettype wire

// ===== sv/window_amplitude_event_detector.sv =====
// Window amplitude event detector. Each push beat (tuser 0) takes one ADC code, centres and
// rectifies it as |2*code - full scale| and shifts it into a delay line of WINDOW cells; the
// running window sum adds the new magnitude and drops the one leaving the last cell. A
// classify beat (tuser 1) compares that sum with the quake, tremor and high thresholds and
// returns one result beat with class, alert level, the sum (saturated to 20 bits) and the
// three wrapping event counters. Before WINDOW samples have been pushed the class is
// insufficient. A new beat is accepted each clock while the skid register is empty; a
// two-deep output register keeps the input open while one result waits. Thresholds are
// written over the APB port at 0x0, 0x4, 0x8.
// Depends on wadet_pkg, wadet_cell and wadet_classify.
`default_nettype none

module window_amplitude_event_detector
  import wadet_pkg::*;
#(
  parameter int unsigned WINDOW      = WINDOW_DEF,
  parameter int unsigned SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  // input stream
  input  wire logic              in_tvalid,
  output logic                   in_tready,
  input  wire logic [15:0]       in_tdata,   // [11:0] adc_code, [15:12] zero
  input  wire logic [0:0]        in_tuser,   // [0] req_type
  // result stream
  output logic                   out_tvalid,
  input  wire logic              out_tready,
  output logic [119:0]           out_tdata,  // [1:0] event_class, [3:2] alert_level,
                                             // [23:4] window_sum, [55:24] total_count,
                                             // [87:56] high_count, [119:88] critical_count
  // configuration
  input  wire logic              cfg_psel,
  input  wire logic              cfg_penable,
  input  wire logic              cfg_pwrite,
  input  wire logic [CFG_AW-1:0] cfg_paddr,
  input  wire logic [CFG_DW-1:0] cfg_pwdata,
  output logic [CFG_DW-1:0]      cfg_prdata,
  output logic                   cfg_pready
);

  localparam int unsigned PTR_W  = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int unsigned SUM_W  = SAMPLE_BITS + PTR_W;
  localparam int unsigned CW     = (SAMPLE_BITS < CODE_W) ? SAMPLE_BITS : CODE_W;
  localparam logic [SAMPLE_BITS:0] FULL_SCALE = {1'b0, {SAMPLE_BITS{1'b1}}};

  // ---------------- configuration ----------------
  thresholds_t thr_r, thr_nxt;
  logic        cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;

  always_comb begin
    thr_nxt = thr_r;
    if (cfg_wr) begin
      case (reg_index_t'(cfg_paddr[3:2]))
        REG_QUAKE_THR:  thr_nxt.quake  = cfg_pwdata[THR_W-1:0];
        REG_TREMOR_THR: thr_nxt.tremor = cfg_pwdata[THR_W-1:0];
        REG_HIGH_THR:   thr_nxt.high   = cfg_pwdata[THR_W-1:0];
        default:        thr_nxt        = thr_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= '{quake: QUAKE_THR_RST, tremor: TREMOR_THR_RST, high: HIGH_THR_RST};
    end else begin
      thr_r <= thr_nxt;
    end
  end

  always_comb begin
    case (reg_index_t'(cfg_paddr[3:2]))
      REG_QUAKE_THR:  cfg_prdata = CFG_DW'(thr_r.quake);
      REG_TREMOR_THR: cfg_prdata = CFG_DW'(thr_r.tremor);
      REG_HIGH_THR:   cfg_prdata = CFG_DW'(thr_r.high);
      default:        cfg_prdata = '0;
    endcase
  end

  // ---------------- input decode ----------------
  logic                   in_beat;
  logic                   push;
  logic                   classify_go;
  logic [CW-1:0]          code;
  logic [SAMPLE_BITS:0]   twice;
  logic [SAMPLE_BITS-1:0] mag;

  assign in_beat     = in_tvalid & in_tready;
  assign push        = in_beat & (in_tuser[0] == REQ_PUSH);
  assign classify_go = in_beat & (in_tuser[0] == REQ_CLASSIFY);
  assign code        = in_tdata[CW-1:0];
  assign twice       = (SAMPLE_BITS + 1)'(code) << 1;

  always_comb begin
    if (twice >= FULL_SCALE) begin
      mag = SAMPLE_BITS'(twice - FULL_SCALE);
    end else begin
      mag = SAMPLE_BITS'(FULL_SCALE - twice);
    end
  end

  // ---------------- delay line of cells ----------------
  logic [SAMPLE_BITS-1:0] tap [WINDOW];

  for (genvar i = 0; i < WINDOW; i++) begin : g_cell
    if (i == 0) begin : g_head
      wadet_cell #(.WIDTH(SAMPLE_BITS)) u_cell (
        .clk      (clk),
        .rst_n    (rst_n),
        .shift_en (push),
        .din      (mag),
        .dout     (tap[i])
      );
    end else begin : g_body
      wadet_cell #(.WIDTH(SAMPLE_BITS)) u_cell (
        .clk      (clk),
        .rst_n    (rst_n),
        .shift_en (push),
        .din      (tap[i-1]),
        .dout     (tap[i])
      );
    end
  end

  // ---------------- running sum and fill ----------------
  logic [SUM_W-1:0] sum_r, sum_nxt;
  logic [PTR_W-1:0] fill_r, fill_nxt;
  logic             full_r, full_nxt;

  always_comb begin
    sum_nxt  = sum_r;
    fill_nxt = fill_r;
    full_nxt = full_r;
    if (push) begin
      sum_nxt = sum_r - SUM_W'(tap[WINDOW-1]) + SUM_W'(mag);
      if (fill_r == PTR_W'(WINDOW - 1)) begin
        fill_nxt = '0;
        full_nxt = 1'b1;
      end else begin
        fill_nxt = fill_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r  <= '0;
      fill_r <= '0;
      full_r <= 1'b0;
    end else begin
      sum_r  <= sum_nxt;
      fill_r <= fill_nxt;
      full_r <= full_nxt;
    end
  end

  // ---------------- classify ----------------
  result_t res;

  wadet_classify #(.SUM_W(SUM_W)) u_classify (
    .clk         (clk),
    .rst_n       (rst_n),
    .classify_go (classify_go),
    .window_full (full_r),
    .sum         (sum_r),
    .thr         (thr_r),
    .result      (res)
  );

  // ---------------- output register with skid ----------------
  logic    out_vld_r, out_vld_nxt;
  logic    skid_vld_r, skid_vld_nxt;
  result_t out_r, out_nxt;
  result_t skid_r, skid_nxt;

  assign in_tready = ~skid_vld_r;

  always_comb begin
    out_vld_nxt  = out_vld_r;
    skid_vld_nxt = skid_vld_r;
    out_nxt      = out_r;
    skid_nxt     = skid_r;
    if (!out_vld_r) begin
      out_vld_nxt = classify_go;
      out_nxt     = res;
    end else if (out_tready) begin
      // advance: skid first, then the new beat
      if (skid_vld_r) begin
        out_nxt      = skid_r;
        skid_vld_nxt = classify_go;
        skid_nxt     = res;
      end else begin
        out_vld_nxt = classify_go;
        out_nxt     = res;
      end
    end else if (classify_go) begin
      skid_vld_nxt = 1'b1;
      skid_nxt     = res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r  <= 1'b0;
      skid_vld_r <= 1'b0;
    end else begin
      out_vld_r  <= out_vld_nxt;
      skid_vld_r <= skid_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r  <= out_nxt;
    skid_r <= skid_nxt;
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {out_r.critical_count, out_r.high_count, out_r.total_count,
                       out_r.window_sum, out_r.alert_level, out_r.event_class};

`ifndef NO_ASSERTIONS
  localparam logic [SUM_W-1:0] SUM_MAX = SUM_W'(WINDOW * ((1 << SAMPLE_BITS) - 1));

  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_vld_r |-> out_vld_r)
    else $error("skid holds a beat while the output register is empty");

  a_full_sticks: assert property (@(posedge clk) disable iff (!rst_n)
    full_r |=> full_r)
    else $error("window full flag dropped");

  a_tail_empty_before_full: assert property (@(posedge clk) disable iff (!rst_n)
    !full_r |-> (tap[WINDOW-1] == '0))
    else $error("last cell filled before the window wrapped");

  a_sum_bound: assert property (@(posedge clk) disable iff (!rst_n)
    sum_r <= SUM_MAX)
    else $error("running sum beyond the largest window sum");
`endif

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
// Self-checking bench for window_amplitude_event_detector: stream driver, result monitor,
// APB register access and a beat-level predictor of the sample ring and classifier.
// Depends on wadet_pkg and the detector RTL only.
`timescale 1ns / 1ps

module tb;
  import wadet_pkg::*;

  localparam int CLK_HALF       = 5;
  localparam int RESET_CYCLES   = 4;
  localparam int DRAIN_CYCLES   = 20;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int PRESS_CYCLES   = 120;
  localparam int FULL_SCALE     = (1 << SAMPLE_BITS_DEF) - 1;

  typedef enum int {
    FLOW_FREE,
    FLOW_SEND_GAPS,
    FLOW_RECV_STALLS,
    FLOW_BOTH
  } flow_mode_t;

  typedef struct {
    logic              req;
    logic [CODE_W-1:0] code;
  } req_beat_t;

  logic              clk         = 1'b0;
  logic              rst_n       = 1'b0;
  logic              in_tvalid   = 1'b0;
  logic              in_tready;
  logic [15:0]       in_tdata    = '0;  // [11:0] adc_code, [15:12] zero
  logic [0:0]        in_tuser    = '0;  // [0] req_type
  logic              out_tvalid;
  logic              out_tready  = 1'b0;
  logic [119:0]      out_tdata;         // [1:0] event_class, [3:2] alert_level,
                                        // [23:4] window_sum, [55:24] total_count,
                                        // [87:56] high_count, [119:88] critical_count
  logic              cfg_psel    = 1'b0;
  logic              cfg_penable = 1'b0;
  logic              cfg_pwrite  = 1'b0;
  logic [CFG_AW-1:0] cfg_paddr   = '0;
  logic [CFG_DW-1:0] cfg_pwdata  = '0;
  logic [CFG_DW-1:0] cfg_prdata;
  logic              cfg_pready;

  window_amplitude_event_detector u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  always #CLK_HALF clk = ~clk;

  // Predictor state: ring of magnitudes, window sum, event counters and thresholds.
  logic [CODE_W-1:0] mag_ring [WINDOW_DEF];
  int unsigned       wr_ptr;
  bit                win_full;
  logic [20:0]       win_sum;
  logic [20:0]       peak_sum;
  logic [CNT_W-1:0]  n_total, n_high, n_crit;
  thresholds_t       thr;

  req_beat_t  req_beats[$];
  result_t    pending_reports[$];
  flow_mode_t flow        = FLOW_FREE;
  bit         press_on    = 1'b0;
  int         press_count = 0;
  bit         in_taken    = 1'b0;
  int         quiet_cycles = 0;
  int         errors      = 0;
  int         beats_taken = 0;
  int         results_seen = 0;
  int         reg_writes  = 0;
  int         class_seen [4] = '{default: 0};

  function automatic void cmp_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
    end
  endfunction

  // Advance the window model by one accepted beat; a classify queues its report.
  task automatic apply_beat(input logic req, input logic [CODE_W-1:0] code);
    int      twice, mag;
    result_t r;
    if (req == REQ_PUSH) begin
      twice = int'(code) * 2;
      mag = (twice >= FULL_SCALE) ? twice - FULL_SCALE : FULL_SCALE - twice;
      win_sum = 21'(win_sum - mag_ring[wr_ptr] + mag);
      mag_ring[wr_ptr] = mag[CODE_W-1:0];
      if (win_sum > peak_sum) peak_sum = win_sum;
      if (wr_ptr == WINDOW_DEF - 1) begin
        wr_ptr = 0;
        win_full = 1'b1;
      end else begin
        wr_ptr++;
      end
    end else begin
      if (!win_full) begin
        r.event_class = CLS_INSUFFICIENT;
        r.alert_level = LVL_NONE;
      end else if (win_sum > thr.quake) begin
        r.event_class = CLS_QUAKE;
        r.alert_level = LVL_CRITICAL;
        n_total++;
        n_crit++;
      end else if (win_sum > thr.tremor) begin
        r.event_class = CLS_TREMOR;
        n_total++;
        if (win_sum >= thr.high) begin
          r.alert_level = LVL_HIGH;
          n_high++;
        end else begin
          r.alert_level = LVL_LOW;
        end
      end else begin
        r.event_class = CLS_NOISE;
        r.alert_level = LVL_NONE;
      end
      r.window_sum     = (win_sum > 21'hFFFFF) ? 20'hFFFFF : win_sum[THR_W-1:0];
      r.total_count    = n_total;
      r.high_count     = n_high;
      r.critical_count = n_crit;
      pending_reports.push_back(r);
    end
  endtask

  function automatic int send_gap_pct();
    case (flow)
      FLOW_SEND_GAPS: return 76;
      FLOW_BOTH:      return 6;
      default:        return 0;
    endcase
  endfunction

  function automatic int recv_stall_pct();
    case (flow)
      FLOW_RECV_STALLS: return 76;
      FLOW_BOTH:        return 6;
      default:          return 0;
    endcase
  endfunction

  // Input driver: hold an unaccepted beat, otherwise offer the next one or idle.
  always @(negedge clk) begin : drive_input
    req_beat_t b;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_taken) begin
      if (req_beats.size() != 0 && $urandom_range(0, 99) >= send_gap_pct()) begin
        b = req_beats.pop_front();
        in_tvalid <= 1'b1;
        in_tdata  <= {4'b0, b.code};
        in_tuser  <= b.req;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Result ready: one long hold-off during the pressure phase, random stalls in the stalling flow modes.
  always @(negedge clk) begin : drive_ready
    if (press_on && press_count < PRESS_CYCLES) begin
      out_tready  <= 1'b0;
      press_count <= press_count + 1;
    end else begin
      out_tready <= ($urandom_range(0, 99) >= recv_stall_pct());
    end
  end

  always @(posedge clk) begin : monitor
    result_t want;
    if (!rst_n) begin
      in_taken <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (pending_reports.size() == 0) begin
          errors++;
          $display("%0t: unexpected result beat: expected none, actual %h", $time, out_tdata);
        end else begin
          want = pending_reports.pop_front();
          cmp_field("event_class", 32'(want.event_class), 32'(out_tdata[1:0]));
          cmp_field("alert_level", 32'(want.alert_level), 32'(out_tdata[3:2]));
          cmp_field("window_sum", 32'(want.window_sum), 32'(out_tdata[23:4]));
          cmp_field("total_count", want.total_count, out_tdata[55:24]);
          cmp_field("high_count", want.high_count, out_tdata[87:56]);
          cmp_field("critical_count", want.critical_count, out_tdata[119:88]);
          class_seen[want.event_class]++;
          results_seen++;
        end
      end
      if (in_tvalid && in_tready) begin
        apply_beat(in_tuser[0], in_tdata[CODE_W-1:0]);
        beats_taken++;
      end
      in_taken <= in_tvalid && in_tready;
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_psel && cfg_penable))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
    end
  end

  always @(posedge clk) begin : watchdog
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: timeout, nothing accepted for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("FAIL");
      $finish;
    end
  end

  task automatic add_beat(input logic req, input logic [CODE_W-1:0] code);
    req_beat_t b;
    b.req  = req;
    b.code = code;
    req_beats.push_back(b);
  endtask

  // Code whose centred magnitude is near 2*amp, either side of mid-scale.
  function automatic logic [CODE_W-1:0] sample_code(int amp);
    int off;
    if ($urandom_range(0, 19) == 0) return CODE_W'($urandom_range(0, FULL_SCALE));
    off = amp + $urandom_range(0, 40) - 20;
    if (off < 0) off = 0;
    if (off > 2047) off = 2047;
    if ($urandom_range(0, 1) == 1) return CODE_W'(2047 - off);
    return CODE_W'(2048 + off);
  endfunction

  // Runs of pushes at one amplitude with classify requests mixed in.
  task automatic add_random(int n, int cls_pct);
    int amp, run_left;
    amp = 0;
    run_left = 0;
    for (int i = 0; i < n; i++) begin
      if (run_left == 0) begin
        amp = $urandom_range(0, 2047);
        run_left = $urandom_range(16, 160);
      end
      run_left--;
      if ($urandom_range(0, 99) < cls_pct)
        add_beat(REQ_CLASSIFY, CODE_W'($urandom_range(0, FULL_SCALE)));
      else
        add_beat(REQ_PUSH, sample_code(amp));
    end
  endtask

  // Wait until every beat is taken and every report is back, then let the pipe empty.
  task automatic settle();
    while (req_beats.size() != 0 || in_tvalid || pending_reports.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input reg_index_t idx, input logic [THR_W-1:0] v);
    logic [CFG_DW-1:0] wdata;
    wdata = $urandom();
    wdata[THR_W-1:0] = v;
    @(negedge clk);
    cfg_psel    = 1'b1;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b1;
    cfg_paddr   = {idx, 2'b00};
    cfg_pwdata  = wdata;
    @(negedge clk);
    cfg_penable = 1'b1;
    @(posedge clk);
    case (idx)
      REG_QUAKE_THR:  thr.quake  = v;
      REG_TREMOR_THR: thr.tremor = v;
      default:        thr.high   = v;
    endcase
    reg_writes++;
    @(negedge clk);
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
  endtask

  task automatic check_reg(input reg_index_t idx);
    logic [THR_W-1:0] want;
    case (idx)
      REG_QUAKE_THR:  want = thr.quake;
      REG_TREMOR_THR: want = thr.tremor;
      default:        want = thr.high;
    endcase
    @(negedge clk);
    cfg_psel    = 1'b1;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
    cfg_paddr   = {idx, 2'b00};
    cfg_pwdata  = $urandom();
    @(negedge clk);
    cfg_penable = 1'b1;
    @(posedge clk);
    cmp_field(idx.name(), 32'(want), 32'(cfg_prdata[THR_W-1:0]));
    @(negedge clk);
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
  endtask

  task automatic program_thresholds(input logic [THR_W-1:0] q, input logic [THR_W-1:0] t,
                                    input logic [THR_W-1:0] h);
    write_reg(REG_QUAKE_THR, q);
    write_reg(REG_TREMOR_THR, t);
    write_reg(REG_HIGH_THR, h);
    check_reg(REG_QUAKE_THR);
    check_reg(REG_TREMOR_THR);
    check_reg(REG_HIGH_THR);
  endtask

  task automatic program_random();
    program_thresholds(THR_W'($urandom_range(0, 20'hFFFFF)),
                       THR_W'($urandom_range(0, 20'hFFFFF)),
                       THR_W'($urandom_range(0, 20'hFFFFF)));
  endtask

  initial begin : stimulus
    logic [THR_W-1:0] bnd;
    foreach (mag_ring[i]) mag_ring[i] = '0;
    wr_ptr   = 0;
    win_full = 1'b0;
    win_sum  = '0;
    peak_sum = '0;
    n_total  = '0;
    n_high   = '0;
    n_crit   = '0;
    thr.quake  = QUAKE_THR_RST;
    thr.tremor = TREMOR_THR_RST;
    thr.high   = HIGH_THR_RST;

    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    check_reg(REG_QUAKE_THR);
    check_reg(REG_TREMOR_THR);
    check_reg(REG_HIGH_THR);

    // Empty window, code extremes and both codes next to mid-scale.
    add_beat(REQ_CLASSIFY, '0);
    add_beat(REQ_PUSH, '0);
    add_beat(REQ_PUSH, CODE_W'(FULL_SCALE));
    add_beat(REQ_CLASSIFY, CODE_W'(FULL_SCALE));
    add_beat(REQ_PUSH, CODE_W'(2047));
    add_beat(REQ_PUSH, CODE_W'(2048));
    add_beat(REQ_CLASSIFY, CODE_W'(12'hA5A));
    // Fill to one short of the window, classify either side of the first wrap.
    begin : fill
      int amp;
      amp = $urandom_range(0, 2047);
      repeat (WINDOW_DEF - 5) add_beat(REQ_PUSH, sample_code(amp));
    end
    add_beat(REQ_CLASSIFY, CODE_W'($urandom_range(0, FULL_SCALE)));
    add_beat(REQ_PUSH, CODE_W'($urandom_range(0, FULL_SCALE)));
    add_beat(REQ_CLASSIFY, CODE_W'($urandom_range(0, FULL_SCALE)));
    add_random(100, 15);
    settle();

    // Threshold extremes: all zero gives quake only, all ones gives noise only.
    program_thresholds('0, '0, '0);
    flow = FLOW_SEND_GAPS;
    add_random(150, 15);
    settle();

    program_thresholds('1, '1, '1);
    flow = FLOW_RECV_STALLS;
    add_random(150, 20);
    settle();

    program_random();
    flow = FLOW_BOTH;
    add_random(250, 15);
    settle();

    // Thresholds placed on the current sum: strict above, at-or-above for high.
    flow = FLOW_FREE;
    bnd = win_sum[THR_W-1:0];
    program_thresholds(bnd, bnd - 1'b1, bnd);
    add_beat(REQ_CLASSIFY, '0);
    settle();
    program_thresholds(bnd, bnd - 1'b1, bnd + 1'b1);
    add_beat(REQ_CLASSIFY, '0);
    settle();
    program_thresholds(bnd, bnd, bnd + 1'b1);
    add_beat(REQ_CLASSIFY, '0);
    settle();
    program_thresholds(bnd - 1'b1, bnd, bnd);
    add_beat(REQ_CLASSIFY, '0);
    settle();

    // Back-pressure: hold results off while classify-heavy traffic keeps arriving.
    program_thresholds(QUAKE_THR_RST, TREMOR_THR_RST, HIGH_THR_RST);
    press_on = 1'b1;
    add_random(120, 50);
    settle();
    press_on = 1'b0;

    for (int p = 0; p < 4; p++) begin
      program_random();
      flow = flow_mode_t'(p);
      add_random(100, 15);
      settle();
    end

    $display("Covered %0d input beats and %0d reports: %0d insufficient, %0d noise,",
             beats_taken, results_seen, class_seen[CLS_INSUFFICIENT], class_seen[CLS_NOISE]);
    $display("%0d tremor, %0d quake; %0d threshold writes; window sum peaked at %0d.",
             class_seen[CLS_TREMOR], class_seen[CLS_QUAKE], reg_writes, peak_sum);
    if (errors == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule

// ===== sim.f =====
sv/wadet_pkg.sv
sv/wadet_cell.sv
sv/wadet_classify.sv
sv/window_amplitude_event_detector.sv
tb/tb.sv
